// ===== hdl/ddd_pkg.sv =====
package ddd_pkg;

  // Field widths, fixed by the data format
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DIST_W  = 22;

  // Day number of any 14-bit year fits in 23 bits
  localparam int unsigned DNUM_W  = 23;

  // Days ahead of month day in the year, before the leap correction
  localparam int unsigned BASE_W  = 9;

  // Reciprocal of 25 in Q16, exact for dividends below 4681
  localparam logic [11:0] RECIP25 = 12'd2622;
  localparam int unsigned RECIP_SH = 16;

  localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
  localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

  // Days in all months before a month index (0 is January), common year
  localparam logic [8:0] DAYS_BEFORE_MONTH [0:11] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Stage advance strobes shared by the day number pipelines
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } ddd_adv_t;

endpackage

// ===== hdl/ddd_in_if.sv =====
interface ddd_in_if;
  logic                          valid;
  logic                          ready;
  logic [ddd_pkg::DAY_W-1:0]     first_day;
  logic [ddd_pkg::MONTH_W-1:0]   first_month;
  logic [ddd_pkg::YEAR_W-1:0]    first_year;
  logic [ddd_pkg::DAY_W-1:0]     second_day;
  logic [ddd_pkg::MONTH_W-1:0]   second_month;
  logic [ddd_pkg::YEAR_W-1:0]    second_year;

  modport source (
    output valid, first_day, first_month, first_year,
    output second_day, second_month, second_year,
    input  ready
  );
  modport sink (
    input  valid, first_day, first_month, first_year,
    input  second_day, second_month, second_year,
    output ready
  );
endinterface

// ===== hdl/ddd_out_if.sv =====
interface ddd_out_if;
  logic                         valid;
  logic                         ready;
  logic [ddd_pkg::DIST_W-1:0]   day_distance;

  modport source (output valid, day_distance, input ready);
  modport sink (input valid, day_distance, output ready);
endinterface

// ===== hdl/ddd_day_number.sv =====
// Four-stage day number pipeline for one date
module ddd_day_number #(
  parameter int unsigned YEAR_LIMIT = 9999
) (
  input  logic                          clk,
  input  ddd_pkg::ddd_adv_t             adv,
  input  logic [ddd_pkg::DAY_W-1:0]     day,
  input  logic [ddd_pkg::MONTH_W-1:0]   month,
  input  logic [ddd_pkg::YEAR_W-1:0]    year,
  output logic [ddd_pkg::DNUM_W-1:0]    day_number
);

  localparam int unsigned LIM_W = 17;

  // Stage 1: clamp month and year, month table
  logic [ddd_pkg::MONTH_W-1:0] m_clamp;
  logic [ddd_pkg::YEAR_W-1:0]  y_clamp;
  logic [ddd_pkg::YEAR_W-1:0]  s1_year;
  logic [ddd_pkg::YEAR_W-1:0]  s1_prior;
  logic [ddd_pkg::BASE_W-1:0]  s1_base;
  logic                        s1_late;

  always_comb begin
    m_clamp = month;
    if (month < ddd_pkg::JANUARY) m_clamp = ddd_pkg::JANUARY;
    if (month > ddd_pkg::DECEMBER) m_clamp = ddd_pkg::DECEMBER;
    y_clamp = year;
    if (year == '0) y_clamp = ddd_pkg::YEAR_W'(1);
    if (LIM_W'(year) > LIM_W'(YEAR_LIMIT)) y_clamp = ddd_pkg::YEAR_W'(YEAR_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      s1_year  <= y_clamp;
      s1_prior <= y_clamp - ddd_pkg::YEAR_W'(1);
      s1_base  <= ddd_pkg::BASE_W'(day) +
                  ddd_pkg::DAYS_BEFORE_MONTH[m_clamp - ddd_pkg::JANUARY];
      s1_late  <= m_clamp > ddd_pkg::FEBRUARY;
    end
  end

  // Stage 2: constant multiplies (365 per year, reciprocals of 25)
  logic [ddd_pkg::YEAR_W-1:0]  s2_year;
  logic [ddd_pkg::YEAR_W-1:0]  s2_prior;
  logic [ddd_pkg::BASE_W-1:0]  s2_base;
  logic                        s2_late;
  logic [ddd_pkg::DNUM_W-1:0]  s2_days365;
  logic [23:0]                 s2_p4_rc;
  logic [21:0]                 s2_p16_rc;
  logic [23:0]                 s2_y4_rc;
  logic [21:0]                 s2_y16_rc;

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      s2_year    <= s1_year;
      s2_prior   <= s1_prior;
      s2_base    <= s1_base;
      s2_late    <= s1_late;
      s2_days365 <= ddd_pkg::DNUM_W'(s1_prior) * ddd_pkg::DNUM_W'(365);
      s2_p4_rc   <= 24'(s1_prior[13:2]) * 24'(ddd_pkg::RECIP25);
      s2_p16_rc  <= 22'(s1_prior[13:4]) * 22'(ddd_pkg::RECIP25);
      s2_y4_rc   <= 24'(s1_year[13:2]) * 24'(ddd_pkg::RECIP25);
      s2_y16_rc  <= 22'(s1_year[13:4]) * 22'(ddd_pkg::RECIP25);
    end
  end

  // Stage 3: century terms and leap year test
  logic [7:0]  p_cent;
  logic [5:0]  p_quad;
  logic [7:0]  y_cent;
  logic [5:0]  y_quad;
  logic        div4;
  logic        div100;
  logic        div400;
  logic        leap;

  assign p_cent = s2_p4_rc[23:ddd_pkg::RECIP_SH];
  assign p_quad = s2_p16_rc[21:ddd_pkg::RECIP_SH];
  assign y_cent = s2_y4_rc[23:ddd_pkg::RECIP_SH];
  assign y_quad = s2_y16_rc[21:ddd_pkg::RECIP_SH];

  always_comb begin
    div4   = s2_year[1:0] == 2'b00;
    div100 = div4 && (s2_year[13:2] == 12'(y_cent) * 12'd25);
    div400 = (s2_year[3:0] == 4'b0000) && (s2_year[13:4] == 10'(y_quad) * 10'd25);
    leap   = div400 || (div4 && !div100);
  end

  logic [ddd_pkg::DNUM_W-1:0]  s3_days365;
  logic [11:0]                 s3_corr;
  logic [ddd_pkg::BASE_W-1:0]  s3_base;
  logic                        s3_extra;

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      s3_days365 <= s2_days365;
      s3_corr    <= s2_prior[13:2] - 12'(p_cent) + 12'(p_quad);
      s3_base    <= s2_base;
      s3_extra   <= s2_late && leap;
    end
  end

  // Stage 4: final sum
  always_ff @(posedge clk) begin
    if (adv.s4) begin
      day_number <= s3_days365 + ddd_pkg::DNUM_W'(s3_corr) +
                    ddd_pkg::DNUM_W'(s3_base) + ddd_pkg::DNUM_W'(s3_extra);
    end
  end

endmodule

// ===== hdl/date_difference_days_unit.sv =====
// Channel    Role    Beat contents
// dates      sink    first_day/month/year, second_day/month/year
// distance   source  day_distance
//
// Five register stages; one beat is taken every cycle unless the output
// stalls with the pipeline full. The depth is set by the constant multiplies
// (365 per year, reciprocal of 25) and the final 23-bit sum and difference.
// Reset clears the stage valid bits only; no item state is kept.
// Each stage holds while the next one is full and stalled, so bubbles are
// squeezed out and a stalled output still lets upstream stages fill.
module date_difference_days_unit #(
  parameter int unsigned YEAR_LIMIT = 9999
) (
  input  logic         clk,
  input  logic         rst,
  ddd_in_if.sink       dates,
  ddd_out_if.source    distance
);

  localparam int unsigned STAGES = 5;

  logic [STAGES:1]   vld;
  logic [STAGES+1:1] en;
  ddd_pkg::ddd_adv_t adv;

  // Stage enables: a stage loads when it is empty or its successor loads
  always_comb begin
    en[STAGES+1] = distance.ready;
    for (int k = STAGES; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
    adv = '{s1: en[1], s2: en[2], s3: en[3], s4: en[4]};
  end

  assign dates.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= dates.valid;
      for (int k = 2; k <= STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Day numbers of both dates
  logic [ddd_pkg::DNUM_W-1:0] num_a;
  logic [ddd_pkg::DNUM_W-1:0] num_b;

  ddd_day_number #(.YEAR_LIMIT(YEAR_LIMIT)) u_first (
    .clk        (clk),
    .adv        (adv),
    .day        (dates.first_day),
    .month      (dates.first_month),
    .year       (dates.first_year),
    .day_number (num_a)
  );

  ddd_day_number #(.YEAR_LIMIT(YEAR_LIMIT)) u_second (
    .clk        (clk),
    .adv        (adv),
    .day        (dates.second_day),
    .month      (dates.second_month),
    .year       (dates.second_year),
    .day_number (num_b)
  );

  // Stage 5: absolute difference, masked to the output width
  logic [ddd_pkg::DNUM_W-1:0] diff;

  always_comb begin
    if (num_a >= num_b) begin
      diff = num_a - num_b;
    end else begin
      diff = num_b - num_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en[STAGES]) distance.day_distance <= diff[ddd_pkg::DIST_W-1:0];
  end

  assign distance.valid = vld[STAGES];

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned YEAR_LIMIT = 9999;
  // Longest run of cycles with no beat on either channel before giving up
  localparam int unsigned STALL_LIMIT = 2000;
  // Drain time after the last expected distance
  localparam int unsigned TAIL_CYCLES = 10;
  localparam int unsigned MAX_REPORTS = 10;

  localparam int unsigned MONTH_DAYS [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    logic [ddd_pkg::DAY_W-1:0]   day;
    logic [ddd_pkg::MONTH_W-1:0] month;
    logic [ddd_pkg::YEAR_W-1:0]  year;
  } date_t;

  logic clk;
  logic rst;

  ddd_in_if  dates_ch ();
  ddd_out_if dist_ch ();

  date_difference_days_unit #(
    .YEAR_LIMIT (YEAR_LIMIT)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .dates    (dates_ch),
    .distance (dist_ch)
  );

  logic [ddd_pkg::DIST_W-1:0] expected_distances [$];
  int unsigned       mismatches;
  int unsigned       idle_cycles;
  // Upper bounds of the per-beat wait each side draws
  int unsigned       send_gap_max;
  int unsigned       take_stall_max;

  // Clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------
  function automatic bit is_leap(int unsigned yr);
    return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
  endfunction

  function automatic int unsigned month_length(int unsigned mon, int unsigned yr);
    return MONTH_DAYS[mon] + ((mon == ddd_pkg::FEBRUARY && is_leap(yr)) ? 1 : 0);
  endfunction

  // Days from the start of year 1 up to and including the given date.
  // Out-of-range month and year are clamped; the day is taken as is.
  function automatic int unsigned day_ordinal(date_t dt);
    int unsigned mon;
    int unsigned yr;
    int unsigned prior;
    int unsigned n;
    mon = dt.month;
    yr  = dt.year;
    if (mon < ddd_pkg::JANUARY) mon = ddd_pkg::JANUARY;
    if (mon > ddd_pkg::DECEMBER) mon = ddd_pkg::DECEMBER;
    if (yr < 1) yr = 1;
    if (yr > YEAR_LIMIT) yr = YEAR_LIMIT;
    prior = yr - 1;
    n = dt.day + 365 * prior + prior / 4 - prior / 100 + prior / 400;
    for (int unsigned k = ddd_pkg::JANUARY; k < mon; k++) begin
      n += month_length(k, yr);
    end
    return n;
  endfunction

  function automatic logic [ddd_pkg::DIST_W-1:0] distance_between(date_t a, date_t b);
    int unsigned na;
    int unsigned nb;
    na = day_ordinal(a);
    nb = day_ordinal(b);
    return (na >= nb) ? ddd_pkg::DIST_W'(na - nb) : ddd_pkg::DIST_W'(nb - na);
  endfunction

  // ---------------------------------------------------------------------------
  // Date builders
  // ---------------------------------------------------------------------------
  function automatic date_t cal(int unsigned d, int unsigned m, int unsigned y);
    date_t dt;
    dt.day   = ddd_pkg::DAY_W'(d);
    dt.month = ddd_pkg::MONTH_W'(m);
    dt.year  = ddd_pkg::YEAR_W'(y);
    return dt;
  endfunction

  // Valid calendar date within the given year span
  function automatic date_t rand_calendar_date(int unsigned lo_year, int unsigned hi_year);
    int unsigned y;
    int unsigned m;
    y = $urandom_range(lo_year, hi_year);
    m = $urandom_range(ddd_pkg::JANUARY, ddd_pkg::DECEMBER);
    return cal($urandom_range(1, month_length(m, y)), m, y);
  endfunction

  // Any bit pattern the fields can carry
  function automatic date_t rand_raw_date();
    return cal($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383));
  endfunction

  // ---------------------------------------------------------------------------
  // Date pair sender: gap, then hold the beat until it is taken
  // ---------------------------------------------------------------------------
  task automatic send_date_pair(date_t a, date_t b);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    repeat (gap) begin
      @(negedge clk);
      dates_ch.valid <= 1'b0;
    end
    @(negedge clk);
    dates_ch.valid        <= 1'b1;
    dates_ch.first_day    <= a.day;
    dates_ch.first_month  <= a.month;
    dates_ch.first_year   <= a.year;
    dates_ch.second_day   <= b.day;
    dates_ch.second_month <= b.month;
    dates_ch.second_year  <= b.year;
    do @(posedge clk); while (!dates_ch.ready);
    expected_distances.push_back(distance_between(a, b));
  endtask

  task automatic lower_dates_valid();
    @(negedge clk);
    dates_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_gap_max   = 0;
    take_stall_max = 0;
    send_date_pair(cal(1, 1, 1), cal(1, 1, 1));
    send_date_pair(cal(31, 12, 9999), cal(1, 1, 1));
    send_date_pair(cal(1, 1, 1), cal(31, 12, 9999));
    // all field bits set against all clear
    send_date_pair(cal(31, 15, 16383), cal(0, 0, 0));
    // day zero, and a day running past the end of February
    send_date_pair(cal(0, 3, 2000), cal(1, 1, 2000));
    send_date_pair(cal(31, 2, 2001), cal(3, 3, 2001));
    // month zero reads as January, months above twelve as December
    send_date_pair(cal(10, 0, 1999), cal(10, 1, 1999));
    send_date_pair(cal(10, 13, 1999), cal(10, 12, 1999));
    send_date_pair(cal(10, 15, 2004), cal(1, 1, 2004));
    // year zero reads as year 1, years past the limit as the limit
    send_date_pair(cal(5, 6, 0), cal(5, 6, 1));
    send_date_pair(cal(5, 6, 10000), cal(1, 1, 1));
    send_date_pair(cal(5, 6, 16383), cal(5, 6, 9999));
    // leap rules: by 400, by 100, by 4, none
    send_date_pair(cal(29, 2, 2000), cal(1, 3, 2000));
    send_date_pair(cal(28, 2, 1900), cal(1, 3, 1900));
    send_date_pair(cal(1, 3, 2024), cal(1, 3, 2023));
    send_date_pair(cal(1, 1, 1601), cal(1, 1, 1600));
    send_date_pair(cal(31, 12, 2100), cal(1, 1, 2100));
    // one pair per month, straddling a leap year
    for (int unsigned m = ddd_pkg::JANUARY; m <= ddd_pkg::DECEMBER; m++) begin
      send_date_pair(cal(15, m, 2000), cal(15, m, 1999));
    end
  endtask

  task automatic test_random_dates(int unsigned count);
    int unsigned lo_year;
    int unsigned hi_year;
    date_t       a;
    date_t       b;
    for (int unsigned i = 0; i < count; i++) begin
      // change the idling mix every 150 beats, with idle-free stretches
      if (i % 150 == 0) begin
        case ((i / 150) % 6)
          0: begin send_gap_max = 11; take_stall_max = 11; end
          1: begin send_gap_max = 0;  take_stall_max = 0;  end
          2: begin send_gap_max = 11; take_stall_max = 0;  end
          3: begin send_gap_max = 0;  take_stall_max = 11; end
          4: begin send_gap_max = 3;  take_stall_max = 11; end
          default: begin send_gap_max = 11; take_stall_max = 3; end
        endcase
      end
      case ($urandom_range(0, 3))
        0: begin
          // both dates in a narrow span
          lo_year = $urandom_range(1, 9998);
          hi_year = lo_year + 1;
        end
        1: begin
          // around a century boundary
          lo_year = $urandom_range(1, 99) * 100 - 1;
          if (lo_year < 1) lo_year = 1;
          hi_year = lo_year + 2;
        end
        default: begin
          lo_year = 1;
          hi_year = YEAR_LIMIT;
        end
      endcase
      a = rand_calendar_date(lo_year, hi_year);
      b = rand_calendar_date(lo_year, hi_year);
      send_date_pair(a, b);
    end
  endtask

  task automatic test_random_raw_fields(int unsigned count);
    date_t a;
    date_t b;
    send_gap_max   = 11;
    take_stall_max = 11;
    for (int unsigned i = 0; i < count; i++) begin
      a = $urandom_range(0, 1) ? rand_raw_date() : rand_calendar_date(1, YEAR_LIMIT);
      b = $urandom_range(0, 1) ? rand_raw_date() : rand_calendar_date(1, YEAR_LIMIT);
      send_date_pair(a, b);
    end
  endtask

  task automatic test_back_to_back(int unsigned count);
    send_gap_max   = 0;
    take_stall_max = 0;
    for (int unsigned i = 0; i < count; i++) begin
      send_date_pair(rand_calendar_date(1, YEAR_LIMIT), rand_calendar_date(1, YEAR_LIMIT));
    end
  endtask

  // Sender stops until the pipeline has fully drained, then resumes
  task automatic test_pause_until_drained(int unsigned count);
    send_gap_max   = 0;
    take_stall_max = 11;
    for (int unsigned i = 0; i < count; i++) begin
      send_date_pair(rand_calendar_date(1, YEAR_LIMIT), rand_calendar_date(1, YEAR_LIMIT));
    end
    lower_dates_valid();
    while (expected_distances.size() != 0) @(posedge clk);
    for (int unsigned i = 0; i < count; i++) begin
      send_date_pair(rand_calendar_date(1, YEAR_LIMIT), rand_calendar_date(1, YEAR_LIMIT));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Distance receiver: random stall before each beat
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    dist_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = $urandom_range(0, take_stall_max);
      repeat (stall) begin
        @(negedge clk);
        dist_ch.ready <= 1'b0;
      end
      @(negedge clk);
      dist_ch.ready <= 1'b1;
      do @(posedge clk); while (!dist_ch.valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking and watchdog
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(string what, logic [ddd_pkg::DIST_W-1:0] want,
                               logic [ddd_pkg::DIST_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s day_distance expected %0d got %0d", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin : check_distances
    logic [ddd_pkg::DIST_W-1:0] want;
    if (!rst) begin
      if (dist_ch.valid && dist_ch.ready) begin
        if (expected_distances.size() == 0) begin
          note_mismatch("unexpected beat:", '0, dist_ch.day_distance);
        end else begin
          want = expected_distances.pop_front();
          if (dist_ch.day_distance !== want) begin
            note_mismatch("mismatch:", want, dist_ch.day_distance);
          end
        end
      end
      // watchdog on beats in either direction
      if ((dist_ch.valid && dist_ch.ready) || (dates_ch.valid && dates_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("timeout: no beat for %0d cycles, %0d distances outstanding",
                   idle_cycles, expected_distances.size());
          $display("tb NOT OK");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatches            = 0;
    idle_cycles           = 0;
    send_gap_max          = 0;
    take_stall_max        = 0;
    rst                   = 1'b1;
    dates_ch.valid        = 1'b0;
    dates_ch.first_day    = '0;
    dates_ch.first_month  = '0;
    dates_ch.first_year   = '0;
    dates_ch.second_day   = '0;
    dates_ch.second_month = '0;
    dates_ch.second_year  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_dates(900);
    test_random_raw_fields(200);
    test_back_to_back(100);
    test_pause_until_drained(40);

    lower_dates_valid();
    while (expected_distances.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_distances.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches, %0d distances outstanding", mismatches,
               expected_distances.size());
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
